>>> rtl/imhq_pkg.sv
// Shared types and constants of the indexed min-heap queue.
// Used by imhq_ctrl, imhq_dp and indexed_min_heap_queue_top; no dependencies.
package imhq_pkg;

  localparam int HEAP_SLOTS_DEF = 512;
  localparam int STOP_W         = 9;
  localparam int STOP_SPAN      = 512;
  localparam int TIME_W         = 20;
  localparam int LINE_W         = 16;
  localparam int TR_W           = 8;
  localparam int PREV_W         = 10;
  localparam int OSTOP_W        = 10;
  localparam int CAP_W          = 10;
  localparam int CNTO_W         = 10;
  localparam logic [CAP_W-1:0] CAP_RST = 10'd512;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef enum logic [1:0] {
    MODE_INS = 2'd0,
    MODE_EXT = 2'd1,
    MODE_DEC = 2'd2,
    MODE_QRY = 2'd3
  } mode_e;

  typedef struct packed {
    logic [STOP_W-1:0]        stop;
    logic [TIME_W-1:0]        tim;
    logic signed [LINE_W-1:0] line;
    logic [TR_W-1:0]          tr;
    logic signed [PREV_W-1:0] prev;
  } heap_item_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_EX1,
    S_EX2,
    S_EX3,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_DN_M,
    S_UP_RD,
    S_UP_C,
    S_UP_M,
    S_MAP,
    S_DKL,
    S_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       ld_in;
    logic       clr;
    logic       ins;
    logic       rd_par;
    logic       up_swap;
    logic       up_map;
    logic       fin;
    logic       ex_root;
    logic       ex_last;
    logic       ex_fix;
    logic       rd_l;
    logic       rd_r;
    logic       dn_swap;
    logic       dn_map;
    logic       dk_ld;
    logic       dk_cur;
    logic       done;
    logic [1:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  empty;
    logic  at_root;
    logic  up_less;
    logic  has_l;
    logic  dn_move;
    logic  absent;
    logic  clr_last;
  } stat_t;

endpackage

>>> rtl/imhq_ctrl.sv
// Controller of the indexed min-heap queue: sequences insert, extract,
// decrease-key and query over the datapath. Depends on imhq_pkg.
module imhq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  imhq_pkg::stat_t stat_i,
  output imhq_pkg::cmd_t  cmd_o
);

  imhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imhq_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != imhq_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = imhq_pkg::ST_OK;
    unique case (state_q)
      imhq_pkg::S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = imhq_pkg::S_IDLE;
      end
      imhq_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.ld_in = 1'b1;
          state_d = imhq_pkg::S_DISP;
        end
      end
      imhq_pkg::S_DISP: begin
        unique case (stat_i.mode)
          imhq_pkg::MODE_INS: begin
            if (stat_i.full) begin
              cmd_o.done = 1'b1;
              cmd_o.code = imhq_pkg::ST_FULL;
              state_d = imhq_pkg::S_IDLE;
            end else begin
              cmd_o.ins = 1'b1;
              state_d = imhq_pkg::S_UP_RD;
            end
          end
          imhq_pkg::MODE_EXT: begin
            if (stat_i.empty) begin
              cmd_o.done = 1'b1;
              cmd_o.code = imhq_pkg::ST_EMPTY;
              state_d = imhq_pkg::S_IDLE;
            end else begin
              state_d = imhq_pkg::S_EX1;
            end
          end
          default: state_d = imhq_pkg::S_MAP;
        endcase
      end
      imhq_pkg::S_EX1: begin
        cmd_o.ex_root = 1'b1;
        state_d = imhq_pkg::S_EX2;
      end
      imhq_pkg::S_EX2: begin
        cmd_o.ex_last = 1'b1;
        state_d = imhq_pkg::S_EX3;
      end
      imhq_pkg::S_EX3: begin
        cmd_o.ex_fix = 1'b1;
        state_d = imhq_pkg::S_DN_L;
      end
      imhq_pkg::S_DN_L: begin
        if (stat_i.has_l) begin
          cmd_o.rd_l = 1'b1;
          state_d = imhq_pkg::S_DN_R;
        end else begin
          state_d = imhq_pkg::S_FIN;
        end
      end
      imhq_pkg::S_DN_R: begin
        cmd_o.rd_r = 1'b1;
        state_d = imhq_pkg::S_DN_C;
      end
      imhq_pkg::S_DN_C: begin
        if (stat_i.dn_move) begin
          cmd_o.dn_swap = 1'b1;
          state_d = imhq_pkg::S_DN_M;
        end else begin
          state_d = imhq_pkg::S_FIN;
        end
      end
      imhq_pkg::S_DN_M: begin
        cmd_o.dn_map = 1'b1;
        state_d = imhq_pkg::S_DN_L;
      end
      imhq_pkg::S_UP_RD: begin
        if (stat_i.at_root) begin
          state_d = imhq_pkg::S_FIN;
        end else begin
          cmd_o.rd_par = 1'b1;
          state_d = imhq_pkg::S_UP_C;
        end
      end
      imhq_pkg::S_UP_C: begin
        if (stat_i.up_less) begin
          cmd_o.up_swap = 1'b1;
          state_d = imhq_pkg::S_UP_M;
        end else begin
          state_d = imhq_pkg::S_FIN;
        end
      end
      imhq_pkg::S_UP_M: begin
        cmd_o.up_map = 1'b1;
        state_d = imhq_pkg::S_UP_RD;
      end
      imhq_pkg::S_MAP: begin
        if (stat_i.mode == imhq_pkg::MODE_QRY) begin
          cmd_o.done = 1'b1;
          state_d = imhq_pkg::S_IDLE;
        end else if (stat_i.absent) begin
          cmd_o.done = 1'b1;
          cmd_o.code = imhq_pkg::ST_ABSENT;
          state_d = imhq_pkg::S_IDLE;
        end else begin
          cmd_o.dk_ld = 1'b1;
          state_d = imhq_pkg::S_DKL;
        end
      end
      imhq_pkg::S_DKL: begin
        cmd_o.dk_cur = 1'b1;
        state_d = imhq_pkg::S_UP_RD;
      end
      imhq_pkg::S_FIN: begin
        cmd_o.fin  = 1'b1;
        cmd_o.done = 1'b1;
        state_d = imhq_pkg::S_IDLE;
      end
      default: state_d = imhq_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/imhq_dp.sv
// Datapath of the indexed min-heap queue: heap memory, stop-to-slot map,
// working registers and result registers. Depends on imhq_pkg.
module imhq_dp #(
  parameter int HEAP_SLOTS = imhq_pkg::HEAP_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  imhq_pkg::cmd_t                     cmd_i,
  output imhq_pkg::stat_t                    stat_o,
  input  logic                               cfg_we_i,
  input  logic [imhq_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic [1:0]                         mode_i,
  input  logic [imhq_pkg::STOP_W-1:0]        entry_stop_i,
  input  logic [imhq_pkg::TIME_W-1:0]        entry_time_i,
  input  logic signed [imhq_pkg::LINE_W-1:0] entry_line_i,
  input  logic [imhq_pkg::TR_W-1:0]          entry_transfers_i,
  input  logic signed [imhq_pkg::PREV_W-1:0] entry_prev_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic signed [imhq_pkg::OSTOP_W-1:0] out_stop_o,
  output logic [imhq_pkg::TIME_W-1:0]        out_time_o,
  output logic signed [imhq_pkg::LINE_W-1:0] out_line_o,
  output logic [imhq_pkg::TR_W-1:0]          out_transfers_o,
  output logic signed [imhq_pkg::PREV_W-1:0] out_prev_o,
  output logic                               is_present_o,
  output logic [imhq_pkg::CNTO_W-1:0]        count_now_o
);

  localparam int SLOT_W = $clog2(HEAP_SLOTS);
  localparam int CNT_W  = $clog2(HEAP_SLOTS + 1);
  localparam int MAP_W  = SLOT_W + 1;
  localparam logic [MAP_W-1:0] NO_SLOT = {1'b1, {SLOT_W{1'b0}}};

  imhq_pkg::heap_item_t heap_mem [HEAP_SLOTS];
  logic [MAP_W-1:0]     map_mem  [imhq_pkg::STOP_SPAN];

  imhq_pkg::heap_item_t h_rd_q, h_wd, cur_q, oth_q, root_q, lch_q, in_q, sel_item;
  logic [SLOT_W-1:0]    h_wa, h_ra, idx_q, sel_q, par, sel_idx;
  logic                 h_we, m_we;
  logic [imhq_pkg::STOP_W-1:0] m_wa, clr_q;
  logic [MAP_W-1:0]     m_wd, m_rd_q;
  logic [imhq_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]     cnt_q;
  imhq_pkg::mode_e      mode_q;
  logic [SLOT_W:0]      lft, rgt;
  logic                 has_r, full;

  assign par = SLOT_W'((idx_q - 1'b1) >> 1);
  assign lft = {idx_q, 1'b1};
  assign rgt = lft + 1'b1;
  assign full = int'(cnt_q) >= ((int'(cap_q) > HEAP_SLOTS) ? HEAP_SLOTS : int'(cap_q));
  assign has_r = {1'b0, rgt} < (SLOT_W + 2)'(cnt_q);

  // pick the smallest of node and children; ties keep the node, then the left
  always_comb begin
    sel_item = cur_q;
    sel_idx  = idx_q;
    if (stat_o.has_l && (lch_q.tim < cur_q.tim)) begin
      sel_item = lch_q;
      sel_idx  = SLOT_W'(lft);
    end
    if (has_r && (h_rd_q.tim < sel_item.tim)) begin
      sel_item = h_rd_q;
      sel_idx  = SLOT_W'(rgt);
    end
  end

  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.full     = full;
    stat_o.empty    = (cnt_q == '0);
    stat_o.at_root  = (idx_q == '0);
    stat_o.up_less  = cur_q.tim < h_rd_q.tim;
    stat_o.has_l    = {1'b0, lft} < (SLOT_W + 2)'(cnt_q);
    stat_o.dn_move  = (sel_idx != idx_q);
    stat_o.absent   = m_rd_q[SLOT_W];
    stat_o.clr_last = &clr_q;
  end

  // heap port
  always_comb begin
    h_ra = '0;
    if (cmd_i.rd_par) h_ra = par;
    if (cmd_i.ex_root) h_ra = SLOT_W'(cnt_q - 1'b1);
    if (cmd_i.rd_l) h_ra = SLOT_W'(lft);
    if (cmd_i.rd_r) h_ra = SLOT_W'(rgt);
    if (cmd_i.dk_ld) h_ra = m_rd_q[SLOT_W-1:0];
    h_we = cmd_i.up_swap | cmd_i.dn_swap | cmd_i.fin;
    h_wa = idx_q;
    h_wd = cur_q;
    if (cmd_i.up_swap) h_wd = h_rd_q;
    if (cmd_i.dn_swap) h_wd = sel_item;
  end

  // map port, at most one write a cycle in the order the sift steps update it
  always_comb begin
    m_we = 1'b1;
    m_wa = clr_q;
    m_wd = NO_SLOT;
    if (cmd_i.ins) begin
      m_wa = in_q.stop;
      m_wd = MAP_W'(cnt_q);
    end else if (cmd_i.up_swap) begin
      m_wa = cur_q.stop;
      m_wd = {1'b0, par};
    end else if (cmd_i.up_map) begin
      m_wa = oth_q.stop;
      m_wd = {1'b0, idx_q};
    end else if (cmd_i.ex_last) begin
      m_wa = root_q.stop;
    end else if (cmd_i.ex_fix) begin
      m_wa = cur_q.stop;
      m_wd = '0;
    end else if (cmd_i.dn_swap) begin
      m_wa = sel_item.stop;
      m_wd = {1'b0, idx_q};
    end else if (cmd_i.dn_map) begin
      m_wa = cur_q.stop;
      m_wd = {1'b0, sel_q};
    end else if (!cmd_i.clr) begin
      m_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    h_rd_q <= heap_mem[h_ra];
  end

  always_ff @(posedge clk_i) begin
    if (m_we) map_mem[m_wa] <= m_wd;
    m_rd_q <= map_mem[in_q.stop];
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      in_q.stop <= entry_stop_i;
      in_q.tim  <= entry_time_i;
      in_q.line <= entry_line_i;
      in_q.tr   <= entry_transfers_i;
      in_q.prev <= entry_prev_i;
    end
    if (cmd_i.ins) begin
      cur_q <= in_q;
      idx_q <= SLOT_W'(cnt_q);
    end
    if (cmd_i.up_swap) oth_q <= h_rd_q;
    if (cmd_i.up_map) idx_q <= par;
    if (cmd_i.ex_root) root_q <= h_rd_q;
    if (cmd_i.ex_last) cur_q <= h_rd_q;
    if (cmd_i.ex_fix) idx_q <= '0;
    if (cmd_i.rd_r) lch_q <= h_rd_q;
    if (cmd_i.dn_swap) sel_q <= sel_idx;
    if (cmd_i.dn_map) idx_q <= sel_q;
    if (cmd_i.dk_ld) idx_q <= m_rd_q[SLOT_W-1:0];
    // keep the stored stop, take the new payload
    if (cmd_i.dk_cur) begin
      cur_q <= '{stop: h_rd_q.stop, tim: in_q.tim, line: in_q.line,
                 tr: in_q.tr, prev: in_q.prev};
    end
    if (cmd_i.done) begin
      status_o <= cmd_i.code;
      is_present_o <= (mode_q == imhq_pkg::MODE_QRY) && !m_rd_q[SLOT_W];
      count_now_o <= imhq_pkg::CNTO_W'(cnt_q);
      if (cmd_i.code == imhq_pkg::ST_EMPTY) begin
        out_stop_o      <= '1;
        out_time_o      <= '1;
        out_line_o      <= '1;
        out_transfers_o <= '1;
        out_prev_o      <= '1;
      end else if (mode_q == imhq_pkg::MODE_EXT) begin
        out_stop_o      <= signed'({1'b0, root_q.stop});
        out_time_o      <= root_q.tim;
        out_line_o      <= root_q.line;
        out_transfers_o <= root_q.tr;
        out_prev_o      <= root_q.prev;
      end else begin
        out_stop_o      <= '0;
        out_time_o      <= '0;
        out_line_o      <= '0;
        out_transfers_o <= '0;
        out_prev_o      <= '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= imhq_pkg::CAP_RST;
      cnt_q  <= '0;
      clr_q  <= '0;
      mode_q <= imhq_pkg::MODE_INS;
      done_o <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.ld_in) mode_q <= imhq_pkg::mode_e'(mode_i);
      if (cmd_i.ins) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.ex_fix) cnt_q <= cnt_q - 1'b1;
      done_o <= cmd_i.done;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= HEAP_SLOTS) else $error("heap count beyond slots");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_empty_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == imhq_pkg::ST_EMPTY) |-> (out_time_o == '1 && count_now_o == '0))
    else $error("empty extract without sentinel");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> !full) else $error("insert past capacity");

endmodule

>>> rtl/indexed_min_heap_queue_top.sv
// Top level of the indexed min-heap queue: controller plus datapath.
// Depends on imhq_pkg, imhq_ctrl and imhq_dp.
//
//  channel   handshake          word
//  in        start / busy       mode_i, entry_*_i
//  out       done_o (1 cycle)   status_o, out_*_o, is_present_o, count_now_o
//  cfg       cfg_we_i           cfg_data_i (capacity_in_use)
//
// Insert and decrease-key climb a level per read-parent, compare, map pass,
// extract sinks one per read-left, read-right, compare, map pass; one heap
// read a cycle sets the pace. Full insert and empty extract end at dispatch,
// query and absent decrease at map lookup. The result is registered and shows
// in the cycle after the operation ends. After reset a pass empties all 512
// stop map entries, busy high. Receivers cannot stall; done_o is one cycle.
module indexed_min_heap_queue_top #(
  parameter int HEAP_SLOTS = imhq_pkg::HEAP_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode_i,
  input  logic [imhq_pkg::STOP_W-1:0]        entry_stop_i,
  input  logic [imhq_pkg::TIME_W-1:0]        entry_time_i,
  input  logic signed [imhq_pkg::LINE_W-1:0] entry_line_i,
  input  logic [imhq_pkg::TR_W-1:0]          entry_transfers_i,
  input  logic signed [imhq_pkg::PREV_W-1:0] entry_prev_i,
  input  logic                               cfg_we_i,
  input  logic [imhq_pkg::CAP_W-1:0]         cfg_data_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic signed [imhq_pkg::OSTOP_W-1:0] out_stop_o,
  output logic [imhq_pkg::TIME_W-1:0]        out_time_o,
  output logic signed [imhq_pkg::LINE_W-1:0] out_line_o,
  output logic [imhq_pkg::TR_W-1:0]          out_transfers_o,
  output logic signed [imhq_pkg::PREV_W-1:0] out_prev_o,
  output logic                               is_present_o,
  output logic [imhq_pkg::CNTO_W-1:0]        count_now_o
);

  imhq_pkg::cmd_t  cmd;
  imhq_pkg::stat_t stat;

  imhq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  imhq_dp #(
    .HEAP_SLOTS(HEAP_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .entry_stop_i      (entry_stop_i),
    .entry_time_i      (entry_time_i),
    .entry_line_i      (entry_line_i),
    .entry_transfers_i (entry_transfers_i),
    .entry_prev_i      (entry_prev_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .out_stop_o        (out_stop_o),
    .out_time_o        (out_time_o),
    .out_line_o        (out_line_o),
    .out_transfers_o   (out_transfers_o),
    .out_prev_o        (out_prev_o),
    .is_present_o      (is_present_o),
    .count_now_o       (count_now_o)
  );

endmodule

>>> tb/tb_indexed_min_heap_queue_top.sv
// Self-checking testbench of indexed_min_heap_queue_top: directed and random
// heap operations checked word by word against an in-bench heap predictor.
// Depends on imhq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module tb_indexed_min_heap_queue_top;

  localparam int SLOTS      = 512;
  localparam int NONE       = -1;
  localparam int CYCLE_MAX  = 1000000;
  localparam int DRAIN_WAIT = 60;

  typedef struct {
    logic [1:0]                   status;
    logic [imhq_pkg::OSTOP_W-1:0] stop;
    logic [imhq_pkg::TIME_W-1:0]  tim;
    logic [imhq_pkg::LINE_W-1:0]  line;
    logic [imhq_pkg::TR_W-1:0]    tr;
    logic [imhq_pkg::PREV_W-1:0]  prev;
    logic                         present;
    logic [imhq_pkg::CNTO_W-1:0]  count;
  } heap_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [1:0]                          mode_i = imhq_pkg::MODE_QRY;
  logic [imhq_pkg::STOP_W-1:0]         entry_stop_i = '0;
  logic [imhq_pkg::TIME_W-1:0]         entry_time_i = '0;
  logic signed [imhq_pkg::LINE_W-1:0]  entry_line_i = '0;
  logic [imhq_pkg::TR_W-1:0]           entry_transfers_i = '0;
  logic signed [imhq_pkg::PREV_W-1:0]  entry_prev_i = '0;
  logic                                cfg_we_i = 1'b0;
  logic [imhq_pkg::CAP_W-1:0]          cfg_data_i = '0;
  logic                                done_o;
  logic [1:0]                          status_o;
  logic signed [imhq_pkg::OSTOP_W-1:0] out_stop_o;
  logic [imhq_pkg::TIME_W-1:0]         out_time_o;
  logic signed [imhq_pkg::LINE_W-1:0]  out_line_o;
  logic [imhq_pkg::TR_W-1:0]           out_transfers_o;
  logic signed [imhq_pkg::PREV_W-1:0]  out_prev_o;
  logic                                is_present_o;
  logic [imhq_pkg::CNTO_W-1:0]         count_now_o;

  // predictor state
  imhq_pkg::heap_item_t heap_mem [SLOTS];
  int                   stop_slot [SLOTS];
  int                   heap_fill;
  int                   cap_reg;
  heap_result_t         pending_results [$];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycles = 0;
  int burst_left = 0;
  int max_fill = 0;

  indexed_min_heap_queue_top u_top (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .entry_stop_i, .entry_time_i,
    .entry_line_i, .entry_transfers_i, .entry_prev_i, .cfg_we_i, .cfg_data_i,
    .done_o, .status_o, .out_stop_o, .out_time_o, .out_line_o,
    .out_transfers_o, .out_prev_o, .is_present_o, .count_now_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void swap_slots(int a, int b);
    imhq_pkg::heap_item_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic void sift_up(int i);
    int p;
    while (i > 0 && i < SLOTS) begin
      p = (i - 1) / 2;
      if (!(heap_mem[i].tim < heap_mem[p].tim)) break;
      stop_slot[heap_mem[i].stop] = p;
      stop_slot[heap_mem[p].stop] = i;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sift_down(int i);
    int l, r, s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < heap_fill && heap_mem[l].tim < heap_mem[s].tim) s = l;
      if (r < heap_fill && heap_mem[r].tim < heap_mem[s].tim) s = r;
      if (s == i) break;
      stop_slot[heap_mem[s].stop] = i;
      stop_slot[heap_mem[i].stop] = s;
      swap_slots(s, i);
      i = s;
    end
  endfunction

  function automatic heap_result_t predict_heap_op(imhq_pkg::mode_e mode,
                                                   imhq_pkg::heap_item_t e);
    heap_result_t         res;
    imhq_pkg::heap_item_t root, last;
    int                   cap, i;
    res = '{default: '0};
    cap = (cap_reg > SLOTS) ? SLOTS : cap_reg;
    case (mode)
      imhq_pkg::MODE_INS: begin
        if (heap_fill >= cap) begin
          res.status = imhq_pkg::ST_FULL;
        end else begin
          i = heap_fill;
          heap_fill++;
          heap_mem[i] = e;
          stop_slot[e.stop] = i;
          sift_up(i);
        end
      end
      imhq_pkg::MODE_EXT: begin
        if (heap_fill == 0) begin
          res.status = imhq_pkg::ST_EMPTY;
          res.stop = '1; res.tim = '1; res.line = '1; res.tr = '1; res.prev = '1;
        end else begin
          root = heap_mem[0];
          last = heap_mem[heap_fill - 1];
          heap_mem[0] = last;
          stop_slot[root.stop] = NONE;
          stop_slot[last.stop] = 0;
          heap_fill--;
          sift_down(0);
          res.stop = {1'b0, root.stop};
          res.tim = root.tim; res.line = root.line;
          res.tr = root.tr; res.prev = root.prev;
        end
      end
      imhq_pkg::MODE_DEC: begin
        i = stop_slot[e.stop];
        if (i == NONE) begin
          res.status = imhq_pkg::ST_ABSENT;
        end else begin
          heap_mem[i].tim = e.tim;
          heap_mem[i].line = e.line;
          heap_mem[i].prev = e.prev;
          heap_mem[i].tr = e.tr;
          sift_up(i);
        end
      end
      default: res.present = (stop_slot[e.stop] != NONE);
    endcase
    res.count = heap_fill[imhq_pkg::CNTO_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    heap_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected (status %0d)", $time, status_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        words_checked++;
        if (status_o !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, status_o);
          errors++;
        end
        if (out_stop_o !== exp_r.stop) begin
          $display("%0t: out_stop exp %h got %h", $time, exp_r.stop, out_stop_o);
          errors++;
        end
        if (out_time_o !== exp_r.tim) begin
          $display("%0t: out_time exp %h got %h", $time, exp_r.tim, out_time_o);
          errors++;
        end
        if (out_line_o !== exp_r.line) begin
          $display("%0t: out_line exp %h got %h", $time, exp_r.line, out_line_o);
          errors++;
        end
        if (out_transfers_o !== exp_r.tr) begin
          $display("%0t: out_transfers exp %h got %h", $time, exp_r.tr, out_transfers_o);
          errors++;
        end
        if (out_prev_o !== exp_r.prev) begin
          $display("%0t: out_prev exp %h got %h", $time, exp_r.prev, out_prev_o);
          errors++;
        end
        if (is_present_o !== exp_r.present) begin
          $display("%0t: is_present exp %0d got %0d", $time, exp_r.present, is_present_o);
          errors++;
        end
        if (count_now_o !== exp_r.count) begin
          $display("%0t: count_now exp %0d got %0d", $time, exp_r.count, count_now_o);
          errors++;
        end
      end
    end
  end

  // Send one word; called at a falling edge, returns at a falling edge.
  task automatic send_word(imhq_pkg::mode_e mode, int stop, int tim, int line, int tr,
                           int prev);
    imhq_pkg::heap_item_t e;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
    burst_left--;
    e.stop = stop[imhq_pkg::STOP_W-1:0];
    e.tim  = tim[imhq_pkg::TIME_W-1:0];
    e.line = line[imhq_pkg::LINE_W-1:0];
    e.tr   = tr[imhq_pkg::TR_W-1:0];
    e.prev = prev[imhq_pkg::PREV_W-1:0];
    start = 1'b1;
    mode_i = mode;
    entry_stop_i = e.stop;
    entry_time_i = e.tim;
    entry_line_i = e.line;
    entry_transfers_i = e.tr;
    entry_prev_i = e.prev;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_results.push_back(predict_heap_op(mode, e));
    words_sent++;
    if (heap_fill > max_fill) max_fill = heap_fill;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic send_random(imhq_pkg::mode_e mode, int stop_hi);
    int line, prev, tim;
    line = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 32767);
    prev = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 511);
    case ($urandom_range(0, 9))
      0:       tim = 0;
      1:       tim = 20'hFFFFF;
      2:       tim = $urandom_range(0, 15);
      default: tim = $urandom_range(0, 20'hFFFFF);
    endcase
    send_word(mode, $urandom_range(0, stop_hi), tim, line, $urandom_range(0, 255), prev);
  endtask

  // Write the capacity only with the block idle.
  task automatic set_capacity(int cap);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = cap[imhq_pkg::CAP_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cap_reg = cap;
  endtask

  task automatic test_empty_cases();
    send_word(imhq_pkg::MODE_EXT, 0, 0, 0, 0, 0);
    send_word(imhq_pkg::MODE_QRY, 511, 0, 0, 0, 0);
    send_word(imhq_pkg::MODE_DEC, 7, 5, 1, 1, 1);
  endtask

  task automatic test_field_extremes();
    send_word(imhq_pkg::MODE_INS, 511, 20'hFFFFF, 32767, 255, 511);
    send_word(imhq_pkg::MODE_INS, 0, 0, -1, 0, -1);
    send_word(imhq_pkg::MODE_INS, 5, 100, 0, 128, 0);
    send_word(imhq_pkg::MODE_INS, 5, 50, 12, 3, 4);      // duplicate stop
    send_word(imhq_pkg::MODE_QRY, 5, 0, 0, 0, 0);
    send_word(imhq_pkg::MODE_DEC, 511, 1, 7, 9, 2);      // climbs toward the top
    send_word(imhq_pkg::MODE_DEC, 5, 0, 1, 1, 1);        // tie at the root stays put
    send_word(imhq_pkg::MODE_QRY, 0, 0, 0, 0, 0);
    repeat (5) send_word(imhq_pkg::MODE_EXT, 0, 0, 0, 0, 0);
    send_word(imhq_pkg::MODE_QRY, 5, 0, 0, 0, 0);        // stale mapping after last extract
    send_word(imhq_pkg::MODE_DEC, 5, 9, 9, 9, 9);
    send_word(imhq_pkg::MODE_INS, 3, 40, 0, 0, 0);
    send_word(imhq_pkg::MODE_EXT, 0, 0, 0, 0, 0);
  endtask

  task automatic test_capacity_limits();
    set_capacity(0);
    send_word(imhq_pkg::MODE_INS, 1, 1, 1, 1, 1);
    set_capacity(1);
    send_word(imhq_pkg::MODE_INS, 1, 1, 1, 1, 1);
    send_word(imhq_pkg::MODE_INS, 2, 0, 1, 1, 1);
    send_word(imhq_pkg::MODE_EXT, 0, 0, 0, 0, 0);
    set_capacity(1023);
  endtask

  // Fill the heap toward its limit, then drain with mixed updates.
  task automatic test_fill_and_drain();
    set_capacity(512);
    repeat (520) begin
      if ($urandom_range(0, 9) == 0) send_random(imhq_pkg::MODE_DEC, 511);
      else send_random(imhq_pkg::MODE_INS, 511);
    end
    while (heap_fill > 0) begin
      case ($urandom_range(0, 5))
        0:       send_random(imhq_pkg::MODE_DEC, 511);
        1:       send_random(imhq_pkg::MODE_QRY, 511);
        default: send_random(imhq_pkg::MODE_EXT, 511);
      endcase
    end
    send_word(imhq_pkg::MODE_EXT, 0, 0, 0, 0, 0);
  endtask

  // Shortest-path style traffic on few stops, so duplicates and stale maps occur.
  task automatic test_random_traffic(int items, int cap);
    int pick;
    set_capacity(cap);
    repeat (items) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) send_random(imhq_pkg::MODE_INS, 63);
      else if (pick < 7) send_random(imhq_pkg::MODE_EXT, 63);
      else if (pick < 9) send_random(imhq_pkg::MODE_DEC, 63);
      else send_random(imhq_pkg::MODE_QRY, 63);
    end
  endtask

  initial begin
    heap_fill = 0;
    cap_reg = int'(imhq_pkg::CAP_RST);
    for (int k = 0; k < SLOTS; k++) stop_slot[k] = NONE;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_cases();
    test_field_extremes();
    test_capacity_limits();
    test_fill_and_drain();
    test_random_traffic(120, 7);
    test_random_traffic(120, 40);
    test_random_traffic(150, 1023);
    test_random_traffic(80, 2);
    set_capacity(512);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("Ran %0d heap operations, %0d results checked, peak heap size %0d,",
             words_sent, words_checked, max_fill);
    $display("capacities 0, 1, 2, 7, 40, 512 and 1023 exercised; %0d mismatches", errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
